// File: sv/ldse_pkg.sv
// Shared types and constants of the linear Diophantine solver.
`timescale 1ns / 1ps
package ldse_pkg;

  localparam int unsigned CoefWidthDef = 32;
  localparam int unsigned FieldW       = 32;
  localparam int unsigned DivW         = 64;
  localparam int unsigned DsrW         = 32;
  localparam int unsigned DivCntW      = $clog2(DivW + 1);

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EU_TEST,
    ST_EU_DIV,
    ST_EU_MUL_S,
    ST_EU_MUL_T,
    ST_EU_UPD,
    ST_C_DIV,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_SCALE_FIX,
    ST_B_DIV,
    ST_A_DIV,
    ST_LIM_DIV,
    ST_LIM_FIX,
    ST_COUNT,
    ST_OUT
  } state_e;

endpackage

// File: sv/ldse_div.sv
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps
module ldse_div import ldse_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            short_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o,
  output logic [DsrW-1:0] rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    quo_q;
  logic [DsrW-1:0]    rem_q;
  logic [DsrW-1:0]    dsr_q;
  logic [DsrW:0]      shifted;
  logic [DsrW+1:0]    diff;
  logic               fits;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign fits    = ~diff[DsrW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= short_i ? DivCntW'(DsrW) : DivCntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // A short division places the narrow dividend at the top so that only
  // DsrW steps are needed; the quotient then lands in the low bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= short_i ? {dividend_i[DsrW-1:0], {(DivW-DsrW){1'b0}}} : dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= fits ? diff[DsrW-1:0] : shifted[DsrW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_o < dsr_q))
    else $error("divider remainder not below divisor");
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not go busy");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q)
    else $error("divider done while still busy");
`endif

endmodule

// File: sv/linear_diophantine_solver_unit.sv
// Top level of the linear Diophantine solver with its sequencer and datapath.
//
// Solves a*x + b*y = c with extended Euclid and counts the solutions inside
// the given x and y bounds. One beat in on the slave channel gives one beat
// out on the master channel. The slave tdata carries a, b, c, x_min, x_max,
// y_min, y_max; the master tuser carries the status and tdata the particular
// solution, the gcd and the count.
// Work runs on one shared bit-serial divider and one 33x33 multiplier under
// a small sequencer, one item at a time; tready is low while an item is in
// work and while its result waits. Each Euclid step is a 32-bit division
// followed by two multiplies and a remainder update, for up to about 46
// steps; then come three 32-bit divisions and up to four 64-bit range
// divisions. The Euclid loop dominates the time an item takes. Both
// coefficients zero gives the degenerate status on the cycle after the beat
// is accepted.
// The result stays on the master channel until taken; a stalled receiver
// holds the block. Reset returns it to idle with no result pending.
`timescale 1ns / 1ps
module linear_diophantine_solver_unit import ldse_pkg::*; #(
  parameter int unsigned COEF_WIDTH = CoefWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coef_a, coef_b, rhs_c, x_min, x_max, y_min, y_max, 32 bits each
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sol_x[63:0], sol_y[127:64], gcd_value[159:128], solution_count[193:160]
  output logic [199:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  function automatic logic signed [FieldW-1:0] sext(input logic [FieldW-1:0] v);
    logic signed [FieldW-1:0] t;
    t = $signed(v << (FieldW - COEF_WIDTH));
    return t >>> (FieldW - COEF_WIDTH);
  endfunction

  function automatic logic [FieldW-1:0] mag32(input logic [FieldW-1:0] v);
    return v[FieldW-1] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [63:0] ext64(input logic [FieldW-1:0] v);
    return {{32{v[FieldW-1]}}, v};
  endfunction

  state_e state_q, state_d;

  logic signed [31:0] a_q, b_q, c_q, xlo_q, xhi_q, ylo_q, yhi_q;
  logic [31:0]        r0_q, r1_q, g_q, qc_q, stepx_q, stepy_q;
  logic signed [33:0] s0_q, s1_q, t0_q, t1_q;
  logic signed [63:0] x_q, y_q, tlo_q, thi_q;
  logic [65:0]        mul_mag_q;
  logic               mul_neg_q;
  logic               stepy_neg_q, have_q, issued_q;
  logic [1:0]         lim_idx_q, status_q;
  logic [33:0]        cnt_q;

  logic signed [31:0] in_a, in_b;
  logic               in_zero, accept;

  logic               div_start, div_short, div_done;
  logic [DivW-1:0]    div_dvd, div_quot;
  logic [DsrW-1:0]    div_dsr, div_rem;

  logic [32:0]        mul_a, mul_b;
  logic               mul_neg;
  logic signed [63:0] prod64;
  logic signed [33:0] prod34;

  logic [33:0]        s0_abs, s1_abs, t0_abs, t1_abs;
  logic               lim_step_neg, pick_hi;
  logic [31:0]        lim_step;
  logic signed [31:0] lim_bound;
  logic signed [63:0] lim_base, lim_num, lim_num_mag, q_plain, q_adj, t_val;
  logic               lim_neg, x_ok, y_ok;

  assign in_a    = sext(s_axis_tdata[31:0]);
  assign in_b    = sext(s_axis_tdata[63:32]);
  assign in_zero = (in_a == 32'sd0) && (in_b == 32'sd0);
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign s0_abs = s0_q[33] ? -s0_q : s0_q;
  assign s1_abs = s1_q[33] ? -s1_q : s1_q;
  assign t0_abs = t0_q[33] ? -t0_q : t0_q;
  assign t1_abs = t1_q[33] ? -t1_q : t1_q;

  assign prod64 = mul_neg_q ? -$signed(mul_mag_q[63:0]) : $signed(mul_mag_q[63:0]);
  assign prod34 = prod64[33:0];

  // Range narrowing: index 0 and 1 bound x, 2 and 3 bound y; even is ceiling.
  assign lim_step_neg = lim_idx_q[1] ? stepy_neg_q : 1'b0;
  assign lim_step     = lim_idx_q[1] ? stepy_q : stepx_q;
  assign pick_hi      = lim_idx_q[0] ^ lim_step_neg;
  assign lim_base     = lim_idx_q[1] ? y_q : x_q;
  assign lim_bound    = lim_idx_q[1] ? (pick_hi ? yhi_q : ylo_q)
                                     : (pick_hi ? xhi_q : xlo_q);
  assign lim_num      = ext64(lim_bound) - lim_base;
  assign lim_num_mag  = lim_num[63] ? -lim_num : lim_num;
  assign lim_neg      = lim_num[63] ^ lim_step_neg;
  assign q_plain      = $signed(div_quot);
  assign q_adj        = q_plain + {63'd0, (div_rem != '0)};
  assign t_val        = !lim_idx_q[0] ? (lim_neg ? -q_plain : q_adj)
                                      : (lim_neg ? -q_adj : q_plain);

  assign x_ok = (stepx_q != '0) || ((x_q >= ext64(xlo_q)) && (x_q <= ext64(xhi_q)));
  assign y_ok = (stepy_q != '0) || ((y_q >= ext64(ylo_q)) && (y_q <= ext64(yhi_q)));

  ldse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .short_i    (div_short),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = in_zero ? ST_OUT : ST_EU_TEST;
        end
      end
      ST_EU_TEST:   state_d = (r1_q == '0) ? ST_C_DIV : ST_EU_DIV;
      ST_EU_DIV:    if (div_done) state_d = ST_EU_MUL_S;
      ST_EU_MUL_S:  state_d = ST_EU_MUL_T;
      ST_EU_MUL_T:  state_d = ST_EU_UPD;
      ST_EU_UPD:    state_d = ST_EU_TEST;
      ST_C_DIV: begin
        if (div_done) begin
          state_d = (div_rem != '0) ? ST_OUT : ST_SCALE_X;
        end
      end
      ST_SCALE_X:   state_d = ST_SCALE_Y;
      ST_SCALE_Y:   state_d = ST_SCALE_FIX;
      ST_SCALE_FIX: state_d = ST_B_DIV;
      ST_B_DIV:     if (div_done) state_d = ST_A_DIV;
      ST_A_DIV: begin
        if (div_done) begin
          state_d = ((stepx_q != '0) || (div_quot[31:0] != '0)) ? ST_LIM_DIV : ST_COUNT;
        end
      end
      ST_LIM_DIV:   if (div_done) state_d = ST_LIM_FIX;
      ST_LIM_FIX: begin
        if ((lim_idx_q == 2'd3) || ((lim_idx_q == 2'd1) && (stepy_q == '0))) begin
          state_d = ST_COUNT;
        end else begin
          state_d = ST_LIM_DIV;
        end
      end
      ST_COUNT:     state_d = ST_OUT;
      ST_OUT:       if (m_axis_tready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    div_short     = 1'b1;
    div_dvd       = '0;
    div_dsr       = g_q;
    mul_a         = '0;
    mul_b         = '0;
    mul_neg       = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_OUT:  m_axis_tvalid = 1'b1;
      ST_EU_DIV: begin
        div_start = !issued_q;
        div_dvd   = {32'd0, r0_q};
        div_dsr   = r1_q;
      end
      ST_EU_MUL_S: begin
        mul_a   = {1'b0, div_quot[31:0]};
        mul_b   = s1_abs[32:0];
        mul_neg = s1_q[33];
      end
      ST_EU_MUL_T: begin
        mul_a   = {1'b0, div_quot[31:0]};
        mul_b   = t1_abs[32:0];
        mul_neg = t1_q[33];
      end
      ST_C_DIV: begin
        div_start = !issued_q;
        div_dvd   = {32'd0, mag32(c_q)};
      end
      ST_SCALE_X: begin
        mul_a   = {1'b0, qc_q};
        mul_b   = s0_abs[32:0];
        mul_neg = s0_q[33] ^ c_q[31] ^ a_q[31];
      end
      ST_SCALE_Y: begin
        mul_a   = {1'b0, qc_q};
        mul_b   = t0_abs[32:0];
        mul_neg = t0_q[33] ^ c_q[31] ^ b_q[31];
      end
      ST_B_DIV: begin
        div_start = !issued_q;
        div_dvd   = {32'd0, mag32(b_q)};
      end
      ST_A_DIV: begin
        div_start = !issued_q;
        div_dvd   = {32'd0, mag32(a_q)};
      end
      ST_LIM_DIV: begin
        div_start = !issued_q;
        div_short = 1'b0;
        div_dvd   = lim_num_mag;
        div_dsr   = lim_step;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        issued_q <= 1'b1;
      end else if (div_done) begin
        issued_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_mag_q <= mul_a * mul_b;
    mul_neg_q <= mul_neg;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          a_q      <= in_a;
          b_q      <= in_b;
          c_q      <= sext(s_axis_tdata[95:64]);
          xlo_q    <= sext(s_axis_tdata[127:96]);
          xhi_q    <= sext(s_axis_tdata[159:128]);
          ylo_q    <= sext(s_axis_tdata[191:160]);
          yhi_q    <= sext(s_axis_tdata[223:192]);
          r0_q     <= mag32(in_a);
          r1_q     <= mag32(in_b);
          s0_q     <= 34'sd1;
          s1_q     <= 34'sd0;
          t0_q     <= 34'sd0;
          t1_q     <= 34'sd1;
          status_q <= in_zero ? STAT_ZERO : STAT_OK;
          x_q      <= '0;
          y_q      <= '0;
          g_q      <= '0;
          cnt_q    <= '0;
          have_q   <= 1'b0;
        end
      end
      ST_EU_TEST: begin
        if (r1_q == '0) begin
          g_q <= r0_q;
        end
      end
      ST_EU_MUL_T: begin
        s0_q <= s1_q;
        s1_q <= s0_q - prod34;
      end
      ST_EU_UPD: begin
        t0_q <= t1_q;
        t1_q <= t0_q - prod34;
        r0_q <= r1_q;
        r1_q <= div_rem;
      end
      ST_C_DIV: begin
        if (div_done) begin
          qc_q <= div_quot[31:0];
          if (div_rem != '0) begin
            status_q <= STAT_NONE;
          end
        end
      end
      ST_SCALE_Y:   x_q <= prod64;
      ST_SCALE_FIX: y_q <= prod64;
      ST_B_DIV: begin
        if (div_done) begin
          stepx_q <= div_quot[31:0];
        end
      end
      ST_A_DIV: begin
        if (div_done) begin
          stepy_q     <= div_quot[31:0];
          stepy_neg_q <= ~a_q[31] ^ b_q[31];
          lim_idx_q   <= (stepx_q != '0) ? 2'd0 : 2'd2;
        end
      end
      ST_LIM_FIX: begin
        if (!lim_idx_q[0]) begin
          tlo_q <= (!have_q || (t_val > tlo_q)) ? t_val : tlo_q;
        end else begin
          thi_q  <= (!have_q || (t_val < thi_q)) ? t_val : thi_q;
          have_q <= 1'b1;
        end
        lim_idx_q <= lim_idx_q + 2'd1;
      end
      ST_COUNT: begin
        if (x_ok && y_ok && have_q && (thi_q >= tlo_q)) begin
          cnt_q <= 34'(thi_q - tlo_q + 64'sd1);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {6'd0, cnt_q, g_q, y_q, x_q};
  assign m_axis_tuser = status_q;

endmodule
